>>> design/ssdt_pkg.sv
// Shared types and constants for the source sequence dedup table.
package ssdt_pkg;

	// Table size and derived widths
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Beat field widths
	localparam int NODE_W = 32;
	localparam int SEQ_W = 32;
	localparam int STORED_SEQ_W = 31;
	localparam int OUTCOME_W = 3;
	localparam int SLOT_W = 6;

	// Result codes
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_IGNORED = 3'd0,
		OUT_NEW     = 3'd1,
		OUT_NEWER   = 3'd2,
		OUT_STALE   = 3'd3,
		OUT_FULL    = 3'd4
	} outcome_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// One table entry
	typedef struct packed {
		logic [NODE_W-1:0]       id;
		logic [STORED_SEQ_W-1:0] seq;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic skip;
		logic hit;
		logic exhausted;
		logic out_free;
	} dp_status_t;

endpackage

>>> design/ssdt_ctrl.sv
// Controller state machine for the source sequence dedup table.
module ssdt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  ssdt_pkg::dp_status_t   status,
	output ssdt_pkg::ctrl_cmd_t    cmd
);
	import ssdt_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   accept;

	assign accept = in_valid && !in_stall;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Pick the next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = status.skip ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.hit || status.exhausted) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Drive commands and the input stall
	always_comb begin
		in_stall   = 1'b1;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> design/ssdt_datapath.sv
// Datapath of the source sequence dedup table: beat registers, table memory, result register.
module ssdt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssdt_pkg::ctrl_cmd_t               cmd,
	output ssdt_pkg::dp_status_t              status,
	input  logic [ssdt_pkg::NODE_W-1:0]       source_node,
	input  logic signed [ssdt_pkg::SEQ_W-1:0] sequence_number,
	input  logic                              report_kind,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ssdt_pkg::OUTCOME_W-1:0]    outcome,
	output logic [ssdt_pkg::SLOT_W-1:0]       slot_touched,
	output logic                              broken_seen
);
	import ssdt_pkg::*;

	// Table memory
	entry_t mem [TABLE_DEPTH];

	// Captured beat
	logic [NODE_W-1:0]       node_q;
	logic [STORED_SEQ_W-1:0] seq_q;
	logic                    kind_q;
	logic                    ignore_q;

	// Scan state
	logic [CNT_W-1:0]        addr_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	entry_t                  rd_data_s1;
	logic                    found_q;
	logic [IDX_W-1:0]        slot_q;
	logic [STORED_SEQ_W-1:0] stored_q;

	// Persistent state and result
	logic [CNT_W-1:0]        used_q;
	logic                    broken_q;
	logic                    out_valid_q;
	outcome_t                outcome_q;
	logic [SLOT_W-1:0]       slot_out_q;

	// Combinational helpers
	logic                    in_skip;
	logic                    issue;
	logic                    match;
	logic                    has_room;
	logic                    is_new;
	logic                    is_newer;
	logic                    out_free;
	logic                    do_out;
	logic                    mem_we;
	logic [IDX_W-1:0]        wr_idx;
	logic [IDX_W-1:0]        slot_n;
	outcome_t                outcome_n;
	logic [SLOT_W+IDX_W-1:0] slot_ext;

	// Flag nonpositive sequence numbers at the port
	assign in_skip = (sequence_number == '0) || sequence_number[SEQ_W-1];

	// Issue one read per scan cycle and compare the entry read in the cycle after the read
	assign issue    = cmd.scan && (addr_q < used_q);
	assign match    = rd_vld_s1 && (rd_data_s1.id == node_q);
	assign has_room = (used_q != CNT_W'(TABLE_DEPTH));

	// Decide the outcome from the scan result
	assign is_new   = !ignore_q && !found_q && has_room;
	assign is_newer = !ignore_q && found_q && (seq_q > stored_q);
	assign out_free = !out_valid_q || !out_stall;
	assign do_out   = cmd.finish && out_free;
	assign mem_we   = do_out && (is_new || is_newer);
	assign wr_idx   = found_q ? slot_q : used_q[IDX_W-1:0];

	always_comb begin
		slot_n = '0;
		priority if (ignore_q) begin
			outcome_n = OUT_IGNORED;
		end else if (found_q) begin
			outcome_n = is_newer ? OUT_NEWER : OUT_STALE;
			slot_n    = slot_q;
		end else if (has_room) begin
			outcome_n = OUT_NEW;
			slot_n    = used_q[IDX_W-1:0];
		end else begin
			outcome_n = OUT_FULL;
		end
	end

	// Mask the slot index to the field width
	assign slot_ext = {{SLOT_W{1'b0}}, slot_n};

	assign status.skip      = in_skip;
	assign status.hit       = match;
	assign status.exhausted = cmd.scan && !issue && !rd_vld_s1;
	assign status.out_free  = out_free;

	// Capture the beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q   <= source_node;
			seq_q    <= sequence_number[STORED_SEQ_W-1:0];
			kind_q   <= report_kind;
			ignore_q <= in_skip;
		end
	end

	// Read and write the table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= '{id: node_q, seq: seq_q};
		end
		if (issue) begin
			rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
			rd_idx_s1  <= addr_q[IDX_W-1:0];
		end
		if (match) begin
			slot_q   <= rd_idx_s1;
			stored_q <= rd_data_s1.seq;
		end
	end

	// Advance the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else if (cmd.load) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else if (cmd.scan) begin
			if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			rd_vld_s1 <= issue;
			if (match) begin
				found_q <= 1'b1;
			end
		end
	end

	// Update the table count, sticky flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			broken_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (do_out) begin
			out_valid_q <= 1'b1;
			if (is_new) begin
				used_q <= used_q + 1'b1;
			end
			if (kind_q && (is_new || is_newer)) begin
				broken_q <= 1'b1;
			end
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (do_out) begin
			outcome_q  <= outcome_n;
			slot_out_q <= slot_ext[SLOT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign slot_touched = slot_out_q;
	assign broken_seen  = broken_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ({1'b0, rd_idx_s1} < {1'b0, used_q}))
		else $error("scan compared an unfilled entry");

	a_broken_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q |=> broken_q)
		else $error("broken flag cleared");

	a_write_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cmd.finish && out_free))
		else $error("table written outside result load");

	a_new_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(do_out && is_new) |=> (used_q == $past(used_q) + 1'b1))
		else $error("new source did not advance entry count");
`endif

endmodule

>>> design/source_sequence_dedup_table_top.sv
// Top level of the source sequence dedup table: controller plus datapath.
//
// Each input beat carries a report's source node, sequence number and kind; each
// produces exactly one result beat. A nonpositive sequence number skips the scan:
// the controller goes straight to the finish state, which loads the result register.
// Otherwise the filled part of the source table is scanned one entry per cycle through
// the single read port of the table memory until a hit or the last filled entry, and
// the finish state then loads the result. The next input beat is accepted in the cycle
// after the result is loaded. The table holds up to 64 entries. A new input beat is
// accepted once the previous report has been written into the result register, even
// while that result is still stalled; a stalled result holds back the load of the
// next one. There is no clearing pass after reset: entries are only read below the
// fill count.
module source_sequence_dedup_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ssdt_pkg::NODE_W-1:0]       source_node,
	input  logic signed [ssdt_pkg::SEQ_W-1:0] sequence_number,
	input  logic                              report_kind,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ssdt_pkg::OUTCOME_W-1:0]    outcome,
	output logic [ssdt_pkg::SLOT_W-1:0]       slot_touched,
	output logic                              broken_seen
);
	import ssdt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence the scan
	ssdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold the table and the result
	ssdt_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.source_node     (source_node),
		.sequence_number (sequence_number),
		.report_kind     (report_kind),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.outcome         (outcome),
		.slot_touched    (slot_touched),
		.broken_seen     (broken_seen)
	);

endmodule
